// ===== design/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: cons must hold in the same cycle as ante.
`define MSPI_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mspi check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define MSPI_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mspi next-cycle check failed");

`endif

// ===== design/mspi_pkg.sv =====
`default_nettype none
package mspi_pkg;

  localparam int POS_W  = 13;
  localparam int SLOT_W = 5;
  localparam int DUR_W  = 16;
  localparam int FL_W   = 10;
  localparam int CNT_W  = 6;
  localparam int FRM_W  = 17;
  localparam int CMD_W  = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD_TARGET  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_CURRENT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START        = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK         = 2'd3;

  localparam logic REG_FRAME_LEN   = 1'b0;
  localparam logic REG_SERVO_COUNT = 1'b1;

  localparam logic [FL_W-1:0]  FRAME_LEN_RESET   = 10'd33;
  localparam logic [CNT_W-1:0] SERVO_COUNT_RESET = 6'd32;
  localparam int               SLOT_LIMIT        = 32;
  localparam int               HOME_POS          = 512;

endpackage
`default_nettype wire

// ===== design/multi_servo_pose_interpolator_core.sv =====
// Channel  | Direction | Beat contents                                       | Handshake
// in_      | input     | command, slot, position, duration_ms                | in_valid / in_stall
// out_     | output    | slot, position, last, move_done                     | out_valid / out_stall
// APB      | slave     | reg 0 frame_length_ms @0x0, reg 1 servo_count @0x4  | psel / penable
//
// One beat at a time. Load writes one entry. Start divides the duration for the frame count,
// then each slot's gap by that count, with the one-bit-a-cycle restoring divider (DW is the
// wider of 16 and the pose width). Tick updates, then reports, each slot in use, read from
// the pose memory through its registered read port; reporting waits on any output stall.
// After reset a clearing pass writes every memory entry, with in_stall high.
// An output beat waits in a register; the report pass holds while that register is full and out_stall is high.
`default_nettype none
module multi_servo_pose_interpolator_core
  import mspi_pkg::*;
#(
  parameter int MAX_SERVOS    = 32,
  parameter int FRACTION_BITS = 3
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  [CMD_W-1:0]        in_command,
  input  wire  [SLOT_W-1:0]       in_slot,
  input  wire  [POS_W-1:0]        in_position,
  input  wire  [DUR_W-1:0]        in_duration_ms,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_last,
  output logic                    out_move_done,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire  [ADDR_W-1:0]       paddr,
  input  wire  [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  localparam int PW    = POS_W + FRACTION_BITS;
  localparam int SW    = PW + 1;
  localparam int AW    = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;
  localparam int DW    = (PW > DUR_W) ? PW : DUR_W;
  localparam int DCW   = $clog2(DW + 1);
  localparam int LIM   = (MAX_SERVOS < SLOT_LIMIT) ? MAX_SERVOS : SLOT_LIMIT;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LD    = 4'd2;
  localparam logic [3:0] S_FDIV  = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_SLD   = 4'd5;
  localparam logic [3:0] S_SDIV  = 4'd6;
  localparam logic [3:0] S_TRD   = 4'd7;
  localparam logic [3:0] S_TUP   = 4'd8;
  localparam logic [3:0] S_ERD   = 4'd9;
  localparam logic [3:0] S_ELD   = 4'd10;

  typedef struct packed {
    logic [PW-1:0] cur;
    logic [PW-1:0] tgt;
    logic [SW-1:0] step;
  } word_t;

  word_t mem [MAX_SERVOS];
  word_t rd_q;
  word_t wr_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          mem_we;

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              moving_r, moving_nxt;
  logic              alld_r, alld_nxt;
  logic              done_r, done_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [FRM_W-1:0]  frames_r, frames_nxt;
  logic [DW-1:0]     dvd_r, dvd_nxt;
  logic [FRM_W-1:0]  dvs_r, dvs_nxt;
  logic [FRM_W-1:0]  rem_r, rem_nxt;
  logic [DCW-1:0]    cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_done_r, out_done_nxt;
  logic [FL_W-1:0]   fl_r;
  logic [CNT_W-1:0]  sc_r;

  logic [CNT_W-1:0]  n_eff;
  logic [FL_W-1:0]   fl_eff;
  logic              in_acc, out_free, idx_last, slot_ok;
  logic              up, near, same, slot_done;
  logic [PW-1:0]     gap, c_new;
  logic [FRM_W:0]    rem_sh, rem_dif;
  logic              ge;
  logic [PW-1:0]     pose_in;

  assign n_eff  = (sc_r > CNT_W'(LIM)) ? CNT_W'(LIM) : sc_r;
  assign fl_eff = (fl_r == '0) ? FL_W'(1) : fl_r;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_last = (idx_r + CNT_W'(1)) == n_eff;
  assign slot_ok  = {1'b0, in_slot} < n_eff;
  assign pose_in  = PW'(pos_r) << FRACTION_BITS;

  assign same      = rd_q.cur == rd_q.tgt;
  assign up        = rd_q.tgt > rd_q.cur;
  assign gap       = up ? (rd_q.tgt - rd_q.cur) : (rd_q.cur - rd_q.tgt);
  assign near      = {1'b0, gap} < rd_q.step;
  assign slot_done = same || near;
  assign c_new     = same ? rd_q.cur :
                     near ? rd_q.tgt :
                     up   ? (rd_q.cur + rd_q.step[PW-1:0]) : (rd_q.cur - rd_q.step[PW-1:0]);

  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign rem_dif = rem_sh - {1'b0, dvs_r};
  assign ge      = rem_sh >= {1'b0, dvs_r};

  assign rd_addr = (state_r == S_IDLE) ? AW'(in_slot) : AW'(idx_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    clr_nxt       = clr_r;
    moving_nxt    = moving_r;
    alld_nxt      = alld_r;
    done_nxt      = done_r;
    cmd_nxt       = cmd_r;
    slot_nxt      = slot_r;
    pos_nxt       = pos_r;
    frames_nxt    = frames_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_slot_nxt  = out_slot_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    mem_we        = 1'b0;
    wr_addr       = AW'(idx_r);
    wr_data       = rd_q;

    if ((state_r == S_FDIV || state_r == S_SDIV) && cnt_r != '0) begin
      dvd_nxt = {dvd_r[DW-2:0], ge};
      rem_nxt = ge ? rem_dif[FRM_W-1:0] : rem_sh[FRM_W-1:0];
      cnt_nxt = cnt_r - DCW'(1);
    end

    unique case (state_r)
      S_CLR: begin
        mem_we   = 1'b1;
        wr_addr  = clr_r;
        wr_data.cur  = PW'(HOME_POS) << FRACTION_BITS;
        wr_data.tgt  = PW'(HOME_POS) << FRACTION_BITS;
        wr_data.step = '0;
        if (clr_r == AW'(MAX_SERVOS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_command;
          slot_nxt = in_slot;
          pos_nxt  = in_position;
          idx_nxt  = '0;
          unique case (in_command) inside
            CMD_LOAD_TARGET, CMD_LOAD_CURRENT: begin
              if (slot_ok) state_nxt = S_LD;
            end
            CMD_START: begin
              dvd_nxt   = DW'(in_duration_ms);
              dvs_nxt   = FRM_W'(fl_eff);
              rem_nxt   = '0;
              cnt_nxt   = DCW'(DW);
              state_nxt = S_FDIV;
            end
            CMD_TICK: begin
              if (moving_r) begin
                if (n_eff == '0) begin
                  moving_nxt = 1'b0;
                end else begin
                  alld_nxt  = 1'b1;
                  state_nxt = S_TRD;
                end
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD: begin
        mem_we  = 1'b1;
        wr_addr = AW'(slot_r);
        if (cmd_r == CMD_LOAD_TARGET) wr_data.tgt = pose_in;
        else wr_data.cur = pose_in;
        state_nxt = S_IDLE;
      end
      S_FDIV: begin
        if (cnt_r == '0) begin
          frames_nxt = FRM_W'(dvd_r[DUR_W-1:0]) + FRM_W'(1);
          if (n_eff == '0) begin
            moving_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: state_nxt = S_SLD;
      S_SLD: begin
        dvd_nxt   = DW'(gap);
        dvs_nxt   = frames_r;
        rem_nxt   = '0;
        cnt_nxt   = DCW'(DW);
        state_nxt = S_SDIV;
      end
      S_SDIV: begin
        if (cnt_r == '0) begin
          mem_we       = 1'b1;
          wr_data.step = SW'(dvd_r[PW-1:0]) + SW'(1);
          if (idx_last) begin
            moving_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = S_SRD;
          end
        end
      end
      S_TRD: state_nxt = S_TUP;
      S_TUP: begin
        mem_we      = 1'b1;
        wr_data.cur = c_new;
        alld_nxt    = alld_r && slot_done;
        if (idx_last) begin
          moving_nxt = !(alld_r && slot_done);
          done_nxt   = alld_r && slot_done;
          idx_nxt    = '0;
          state_nxt  = S_ERD;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_TRD;
        end
      end
      S_ERD: state_nxt = S_ELD;
      S_ELD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = idx_r[SLOT_W-1:0];
          out_pos_nxt   = rd_q.cur[PW-1 -: POS_W];
          out_last_nxt  = idx_last;
          out_done_nxt  = done_r;
          if (idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      clr_r       <= '0;
      moving_r    <= 1'b0;
      alld_r      <= 1'b0;
      done_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      fl_r        <= FRAME_LEN_RESET;
      sc_r        <= SERVO_COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      clr_r       <= clr_nxt;
      moving_r    <= moving_nxt;
      alld_r      <= alld_nxt;
      done_r      <= done_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_FRAME_LEN) fl_r <= pwdata[FL_W-1:0];
        else sc_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    slot_r     <= slot_nxt;
    pos_r      <= pos_nxt;
    frames_r   <= frames_nxt;
    dvd_r      <= dvd_nxt;
    dvs_r      <= dvs_nxt;
    rem_r      <= rem_nxt;
    out_slot_r <= out_slot_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    if (paddr[2] == REG_FRAME_LEN) prdata = DATA_W'(fl_r);
    else prdata = DATA_W'(sc_r);
  end

  assign pready        = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_position  = out_pos_r;
  assign out_last      = out_last_r;
  assign out_move_done = out_done_r;

`include "assert_macros.svh"

  `MSPI_CHECK(a_out_from_report, $rose(out_valid_r), $past(state_r == S_ELD))
  `MSPI_CHECK(a_move_from_start, $rose(moving_r),
              $past(state_r == S_SDIV) || $past(state_r == S_FDIV))
  `MSPI_CHECK(a_idx_in_range, state_r == S_TUP || state_r == S_ELD || state_r == S_SDIV,
              idx_r < n_eff)
  `MSPI_CHECK_NEXT(a_tick_idle, in_acc && in_command == CMD_TICK && !moving_r,
                   state_r == S_IDLE)

endmodule
`default_nettype wire

// ===== bench/multi_servo_pose_interpolator_core_test.sv =====
`default_nettype none
module multi_servo_pose_interpolator_core_test;
  import mspi_pkg::*;

  localparam int MAX_SERVOS     = 32;
  localparam int FRACTION_BITS  = 3;
  localparam int POSE_W         = POS_W + FRACTION_BITS;
  localparam int QUIET_CYCLES   = 1000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_BEATS    = 24;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  position;
    logic [DUR_W-1:0]  duration_ms;
    bit                drain_first;
  } servo_cmd_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  position;
    logic              last;
    logic              move_done;
  } pose_report_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command     = CMD_TICK;
  logic [SLOT_W-1:0] in_slot        = '0;
  logic [POS_W-1:0]  in_position    = '0;
  logic [DUR_W-1:0]  in_duration_ms = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [SLOT_W-1:0] out_slot;
  logic [POS_W-1:0]  out_position;
  logic              out_last;
  logic              out_move_done;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [ADDR_W-1:0] paddr          = '0;
  logic [DATA_W-1:0] pwdata         = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  multi_servo_pose_interpolator_core #(
    .MAX_SERVOS   (MAX_SERVOS),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_slot       (in_slot),
    .in_position   (in_position),
    .in_duration_ms(in_duration_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_slot      (out_slot),
    .out_position  (out_position),
    .out_last      (out_last),
    .out_move_done (out_move_done),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the block's pose memories and registers
  logic [POSE_W-1:0] cur_pose [MAX_SERVOS];
  logic [POSE_W-1:0] tgt_pose [MAX_SERVOS];
  logic [POSE_W:0]   step_len [MAX_SERVOS];
  bit                moving;
  logic [FL_W-1:0]   frame_len;
  logic [CNT_W-1:0]  slot_count;

  servo_cmd_t   pending_cmds[$];
  pose_report_t expected_reports[$];
  servo_cmd_t   held_cmd;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned failures      = 0;
  int unsigned cmds_queued   = 0;
  int unsigned cmd_beats     = 0;
  int unsigned report_beats  = 0;
  int unsigned settings_run  = 0;
  int unsigned quiet_count   = 0;

  function automatic int unsigned slots_in_use();
    return (slot_count > MAX_SERVOS) ? MAX_SERVOS : slot_count;
  endfunction

  function automatic void predict_servo_reports(servo_cmd_t c);
    int unsigned  n;
    int unsigned  fl;
    int unsigned  frames;
    int unsigned  gap;
    int unsigned  pending;
    pose_report_t r;
    n = slots_in_use();
    case (c.command) inside
      CMD_LOAD_TARGET, CMD_LOAD_CURRENT: begin
        if (c.slot < n) begin
          if (c.command == CMD_LOAD_TARGET)
            tgt_pose[c.slot] = POSE_W'(c.position) << FRACTION_BITS;
          else
            cur_pose[c.slot] = POSE_W'(c.position) << FRACTION_BITS;
        end
      end
      CMD_START: begin
        fl = (frame_len == 0) ? 1 : frame_len;
        frames = c.duration_ms / fl + 1;
        for (int i = 0; i < n; i++) begin
          gap = (tgt_pose[i] > cur_pose[i]) ? tgt_pose[i] - cur_pose[i]
                                            : cur_pose[i] - tgt_pose[i];
          step_len[i] = (POSE_W+1)'(gap / frames + 1);
        end
        moving = 1'b1;
      end
      CMD_TICK: begin
        if (moving) begin
          pending = n;
          for (int i = 0; i < n; i++) begin
            if (cur_pose[i] == tgt_pose[i]) begin
              pending--;
            end else begin
              gap = (tgt_pose[i] > cur_pose[i]) ? tgt_pose[i] - cur_pose[i]
                                                : cur_pose[i] - tgt_pose[i];
              if (gap < step_len[i]) begin
                cur_pose[i] = tgt_pose[i];
                pending--;
              end else if (tgt_pose[i] > cur_pose[i]) begin
                cur_pose[i] = POSE_W'(cur_pose[i] + step_len[i]);
              end else begin
                cur_pose[i] = POSE_W'(cur_pose[i] - step_len[i]);
              end
            end
          end
          if (pending == 0) moving = 1'b0;
          for (int i = 0; i < n; i++) begin
            r.slot      = SLOT_W'(i);
            r.position  = POS_W'(cur_pose[i] >> FRACTION_BITS);
            r.last      = (i == n - 1);
            r.move_done = (pending == 0);
            expected_reports.push_back(r);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t  %s mismatch: expected %0d, got %0d", $time, what, want, got);
      failures++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_servo_reports(held_cmd);
        cmd_beats++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct &&
            (!pending_cmds[0].drain_first || expected_reports.size() == 0)) begin
          held_cmd = pending_cmds.pop_front();
          in_command     <= held_cmd.command;
          in_slot        <= held_cmd.slot;
          in_position    <= held_cmd.position;
          in_duration_ms <= held_cmd.duration_ms;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : report_check
    pose_report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t  unexpected result: expected none, got slot %0d position %0d",
                   $time, out_slot, out_position);
          failures++;
        end else begin
          want = expected_reports.pop_front();
          check_field("slot", want.slot, out_slot);
          check_field("position", want.position, out_position);
          check_field("last", want.last, out_last);
          check_field("move_done", want.move_done, out_move_done);
          report_beats++;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_count = 0;
      else quiet_count++;
      if (quiet_count >= WATCHDOG_LIMIT) begin
        $display("%0t  timeout: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                           logic [POS_W-1:0] pos, logic [DUR_W-1:0] dur, bit drain);
    servo_cmd_t c;
    c.command     = cmd;
    c.slot        = slot;
    c.position    = pos;
    c.duration_ms = dur;
    c.drain_first = drain;
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic wait_for_quiet();
    while (pending_cmds.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    // a start or load gives no result, so the block may still be busy
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, logic regsel, logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({regsel, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(logic regsel, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] stored;
    stored = (regsel == REG_FRAME_LEN) ? DATA_W'(value[FL_W-1:0]) : DATA_W'(value[CNT_W-1:0]);
    apb_access(1'b1, regsel, value, rd);
    apb_access(1'b0, regsel, '0, rd);
    check_field("register readback", stored, rd);
    if (regsel == REG_FRAME_LEN) frame_len = value[FL_W-1:0];
    else slot_count = value[CNT_W-1:0];
    settings_run++;
  endtask

  task automatic queue_move_sequence(bit drain);
    int unsigned slots;
    int unsigned fl;
    int unsigned frames;
    int unsigned loads;
    int unsigned ticks;
    int unsigned dur;
    slots = (slots_in_use() == 0) ? 1 : slots_in_use();
    fl = (frame_len == 0) ? 1 : frame_len;
    loads = $urandom_range(1, 4);
    for (int i = 0; i < loads; i++)
      queue_cmd(($urandom_range(3) == 0) ? CMD_LOAD_CURRENT : CMD_LOAD_TARGET,
                SLOT_W'($urandom_range(slots - 1)), POS_W'($urandom_range(8191)),
                DUR_W'($urandom), drain && i == 0);
    frames = $urandom_range(0, 5);
    dur = frames * fl + $urandom_range(fl - 1);
    if (dur > 65535 || $urandom_range(7) == 0) dur = $urandom_range(65535);
    queue_cmd(CMD_START, SLOT_W'($urandom), POS_W'($urandom), DUR_W'(dur), 1'b0);
    ticks = $urandom_range(1, frames + 2);
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(5) == 0)
        queue_cmd(CMD_LOAD_TARGET, SLOT_W'($urandom_range(slots - 1)),
                  POS_W'($urandom_range(8191)), DUR_W'($urandom), 1'b0);
      queue_cmd(CMD_TICK, SLOT_W'($urandom), POS_W'($urandom), DUR_W'($urandom), 1'b0);
    end
  endtask

  task automatic run_random_phase(int unsigned fl, int unsigned cnt, int unsigned idle,
                                  int unsigned stall, bit drain);
    int unsigned first;
    wait_for_quiet();
    write_reg(REG_FRAME_LEN, fl);
    write_reg(REG_SERVO_COUNT, cnt);
    send_idle_pct = idle;
    stall_pct     = stall;
    first = cmds_queued;
    while (cmds_queued - first < PHASE_BEATS) begin
      if ($urandom_range(4) == 0)
        queue_cmd(CMD_W'($urandom), SLOT_W'($urandom), POS_W'($urandom),
                  DUR_W'($urandom), 1'b0);
      else
        queue_move_sequence(drain);
    end
  endtask

  initial begin
    frame_len  = FRAME_LEN_RESET;
    slot_count = SERVO_COUNT_RESET;
    moving     = 1'b0;
    for (int i = 0; i < MAX_SERVOS; i++) begin
      cur_pose[i] = POSE_W'(HOME_POS) << FRACTION_BITS;
      tgt_pose[i] = POSE_W'(HOME_POS) << FRACTION_BITS;
      step_len[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero frame length, four slots
    wait_for_quiet();
    write_reg(REG_FRAME_LEN, 0);
    write_reg(REG_SERVO_COUNT, 4);
    queue_cmd(CMD_TICK, 0, 0, 0, 1'b0);
    queue_cmd(CMD_LOAD_TARGET, 0, 8191, 0, 1'b0);
    queue_cmd(CMD_LOAD_TARGET, 1, 0, 0, 1'b0);
    queue_cmd(CMD_LOAD_CURRENT, 1, 8191, 0, 1'b0);
    queue_cmd(CMD_LOAD_CURRENT, 0, 0, 0, 1'b0);
    queue_cmd(CMD_LOAD_TARGET, 31, 100, 0, 1'b0);
    queue_cmd(CMD_LOAD_TARGET, 3, 512, 0, 1'b0);
    queue_cmd(CMD_START, 0, 0, 0, 1'b0);
    queue_cmd(CMD_TICK, 31, 8191, 65535, 1'b0);
    queue_cmd(CMD_TICK, 0, 0, 0, 1'b0);
    queue_cmd(CMD_LOAD_TARGET, 0, 0, 65535, 1'b0);
    queue_cmd(CMD_START, 31, 8191, 65535, 1'b0);
    queue_cmd(CMD_TICK, 0, 0, 0, 1'b0);
    queue_cmd(CMD_TICK, 0, 0, 0, 1'b0);
    queue_cmd(CMD_START, 0, 0, 7, 1'b0);
    queue_cmd(CMD_LOAD_TARGET, 2, 8191, 0, 1'b0);
    queue_cmd(CMD_TICK, 0, 0, 0, 1'b0);
    queue_cmd(CMD_TICK, 0, 0, 0, 1'b0);

    // directed: no slots in use
    wait_for_quiet();
    write_reg(REG_SERVO_COUNT, 0);
    queue_cmd(CMD_START, 0, 0, 100, 1'b0);
    queue_cmd(CMD_TICK, 0, 0, 0, 1'b0);
    queue_cmd(CMD_LOAD_TARGET, 0, 4095, 0, 1'b0);
    queue_cmd(CMD_TICK, 0, 0, 0, 1'b0);

    run_random_phase(1000, 32, 0, 0, 1'b0);
    run_random_phase(1, 1, 68, 0, 1'b0);
    run_random_phase(1023, 63, 0, 68, 1'b0);
    run_random_phase(517, 33, 23, 23, 1'b0);
    run_random_phase(5, 7, 0, 0, 1'b1);
    wait_for_quiet();

    $display("Covered %0d command beats and %0d pose reports across %0d register writes,",
             cmd_beats, report_beats, settings_run);
    $display("with zero frame length, zero and oversized slot counts and all stall modes.");
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/mspi_pkg.sv
design/multi_servo_pose_interpolator_core.sv
bench/multi_servo_pose_interpolator_core_test.sv
